FILE: src/image_kernel_convolution_assert.svh
// assertion macros for the image kernel convolution block
// used by the top level; expects clk and rst_n in the including scope
`ifndef IMAGE_KERNEL_CONVOLUTION_ASSERT_SVH
`define IMAGE_KERNEL_CONVOLUTION_ASSERT_SVH
`ifndef SYNTHESIS
`define IKC_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("ikc assertion failed");
`define IKC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ikc assertion failed");
`else
`define IKC_ASSERT(lbl, expr)
`define IKC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/ikc_pkg.sv
// shared types and constants of the image kernel convolution block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ikc_pkg;

  localparam int PIX_BITS      = 24;
  localparam int ROW_BITS      = 11;
  localparam int COL_MAX_BITS  = 12;
  localparam int SLOT_MAX_BITS = 3;
  localparam int WIDTH_BITS    = 13;
  localparam int COEF_REG_BITS = 60;
  localparam int COEF_ROWS     = 5;
  localparam int RADIUS_CAP    = 2;
  localparam int HEIGHT_CAP    = 1024;
  localparam int ROUND_HALF    = 128;
  localparam int SAT_LIMIT     = 65535;
  localparam int CFG_ADDR_BITS = 6;
  localparam int CFG_DATA_BITS = 64;

  typedef logic [PIX_BITS-1:0] pixel_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_RADIUS = 3'd0,
    REG_WIDTH  = 3'd1,
    REG_HEIGHT = 3'd2,
    REG_COEF0  = 3'd3,
    REG_COEF1  = 3'd4,
    REG_COEF2  = 3'd5,
    REG_COEF3  = 3'd6,
    REG_COEF4  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [ROW_BITS-1:0]      row;
    logic [COL_MAX_BITS-1:0]  col;
    logic [SLOT_MAX_BITS-1:0] slot;
    logic                     frame_end;
  } tok_t;

  typedef struct packed {
    logic [1:0]            radius;
    logic [WIDTH_BITS-1:0] width;
    logic [ROW_BITS-1:0]   height;
  } geom_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } res_t;

endpackage
`default_nettype wire

FILE: src/ikc_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module ikc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: src/ikc_filter.sv
// tap selection, multiply and sum pipeline of the convolution block
// depends on ikc_pkg; fed by the line store reads of the top level
`timescale 1ns / 1ps
`default_nettype none
module ikc_filter #(
  parameter int MAX_RADIUS = 2,
  parameter int COEF_BITS  = 12
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          tok_valid,
  input  wire ikc_pkg::tok_t  tok,
  input  wire ikc_pkg::geom_t geom,
  input  wire logic [ikc_pkg::COEF_REG_BITS-1:0] coef [ikc_pkg::COEF_ROWS],
  input  wire ikc_pkg::pixel_t win [2*MAX_RADIUS+2][1 << $clog2(2*((MAX_RADIUS < 2) ?
                                    MAX_RADIUS : 2)+1)],
  output logic               res_valid,
  output ikc_pkg::res_t      res
);
  import ikc_pkg::*;

  localparam int KR   = (MAX_RADIUS < RADIUS_CAP) ? MAX_RADIUS : RADIUS_CAP;
  localparam int TAPS = 2 * KR + 1;
  localparam int NBL  = $clog2(TAPS);
  localparam int NB   = 1 << NBL;
  localparam int RING = 2 * MAX_RADIUS + 2;
  localparam int SW   = $clog2(RING);
  localparam int PW   = COEF_BITS + 9;
  localparam int RSW  = PW + 3;
  localparam int TW   = PW + 6;
  localparam int CEW  = (COEF_BITS * COEF_ROWS > COEF_REG_BITS) ?
                        COEF_BITS * COEF_ROWS : COEF_REG_BITS;

  pixel_t                 tap_c [TAPS][TAPS];
  logic signed [COEF_BITS-1:0] k_c [TAPS][TAPS];
  pixel_t                 centre;

  pixel_t                 tap_r  [TAPS][TAPS];
  logic signed [PW-1:0]   prod_r [TAPS][TAPS][3];
  logic signed [RSW-1:0]  rs_c   [TAPS][3];
  logic signed [RSW-1:0]  rs_r   [TAPS][3];
  logic signed [TW-1:0]   tot_c  [3];
  logic [7:0]             ch_c   [3];
  logic s2_valid_r, s3_valid_r, s4_valid_r;
  logic s2_fe_r, s3_fe_r, s4_fe_r;

  assign centre = win[tok.slot[SW-1:0]][tok.col[NBL-1:0]];

  for (genvar gi = 0; gi < TAPS; gi++) begin : g_row
    for (genvar gj = 0; gj < TAPS; gj++) begin : g_col
      localparam int DY   = gi - KR;
      localparam int DX   = gj - KR;
      localparam int ADY  = (DY < 0) ? -DY : DY;
      localparam int ADX  = (DX < 0) ? -DX : DX;
      localparam int CROW = DY + 2;
      localparam int LANE = DX + 2;
      logic signed [ROW_BITS+1:0]     ty;
      logic signed [COL_MAX_BITS+1:0] tx;
      logic [SW+2:0]                  st;
      logic [SW-1:0]                  sl;
      logic [NBL-1:0]                 bk;
      logic                           row_ok, col_ok, active;
      logic [CEW-1:0]                 cext;

      assign ty = $signed({2'b00, tok.row}) + (ROW_BITS+2)'(DY);
      assign tx = $signed({2'b00, tok.col}) + (COL_MAX_BITS+2)'(DX);
      assign row_ok = (ty >= 0) && (ty < $signed({2'b00, geom.height}));
      assign col_ok = (tx >= 0) && (tx < $signed({1'b0, geom.width}));
      assign st = (SW+3)'(tok.slot[SW-1:0]) + (SW+3)'(RING + DY);
      assign sl = (st >= (SW+3)'(RING)) ? SW'(st - (SW+3)'(RING)) : SW'(st);
      assign bk = tok.col[NBL-1:0] + NBL'(NB + DX);
      // taps outside the radius may sit on rows not yet received
      assign tap_c[gi][gj] = !active ? '0 : (row_ok && col_ok) ? win[sl][bk] : centre;
      assign cext = CEW'(coef[CROW]);
      assign active = (2'(ADY) <= geom.radius) && (2'(ADX) <= geom.radius);
      assign k_c[gi][gj] = active ? $signed(cext[COEF_BITS*LANE +: COEF_BITS]) : '0;
    end
  end

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      for (int c = 0; c < 3; c++) begin
        rs_c[i][c] = '0;
        for (int j = 0; j < TAPS; j++) begin
          rs_c[i][c] = rs_c[i][c] + RSW'(prod_r[i][j][c]);
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tot_c[c] = TW'(ROUND_HALF);
      for (int i = 0; i < TAPS; i++) begin
        tot_c[c] = tot_c[c] + TW'(rs_r[i][c]);
      end
      if (tot_c[c] < 0) begin
        ch_c[c] = 8'd0;
      end else if (tot_c[c] > $signed(TW'(SAT_LIMIT))) begin
        ch_c[c] = 8'd255;
      end else begin
        ch_c[c] = tot_c[c][15:8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= tok_valid;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_fe_r <= tok.frame_end;
      s3_fe_r <= s2_fe_r;
      s4_fe_r <= s3_fe_r;
      for (int i = 0; i < TAPS; i++) begin
        for (int j = 0; j < TAPS; j++) begin
          tap_r[i][j] <= tap_c[i][j];
          for (int c = 0; c < 3; c++) begin
            prod_r[i][j][c] <= $signed({1'b0, tap_r[i][j][8*(2-c) +: 8]}) * k_c[i][j];
          end
        end
        for (int c = 0; c < 3; c++) begin
          rs_r[i][c] <= rs_c[i][c];
        end
      end
    end
  end

  assign res_valid     = s4_valid_r;
  assign res.red       = ch_c[0];
  assign res.green     = ch_c[1];
  assign res.blue      = ch_c[2];
  assign res.frame_end = s4_fe_r;

endmodule
`default_nettype wire

FILE: src/image_kernel_convolution.sv
// rgb raster convolution: one result per accepted transaction at most, in raster order
// results pass the s1 read, filter tap, product and row-sum, and output registers
// throughput: one transaction per cycle unless out_ready stalls; one read gives all taps
// line store is banked by ring row and column phase so every window comes from one read
// reset: synchronous active low; counters and registers to defaults, line store not cleared
// depends on ikc_pkg, ikc_ram, ikc_filter and image_kernel_convolution_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "image_kernel_convolution_assert.svh"
module image_kernel_convolution #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 2,
  parameter int COEF_BITS  = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             out_frame_end,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [ikc_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [ikc_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic      [ikc_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic             pready
);
  import ikc_pkg::*;

  localparam int KR     = (MAX_RADIUS < RADIUS_CAP) ? MAX_RADIUS : RADIUS_CAP;
  localparam int TAPS   = 2 * KR + 1;
  localparam int NBL    = $clog2(TAPS);
  localparam int NB     = 1 << NBL;
  localparam int RING   = 2 * MAX_RADIUS + 2;
  localparam int SW     = $clog2(RING);
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int BD     = (MAX_WIDTH + NB - 1) / NB;
  localparam int RDEPTH = (BD < 2) ? 2 : BD;
  localparam int AW     = $clog2(RDEPTH);
  localparam int XW     = CW + NBL + 2;
  localparam int RB     = ROW_BITS;

  // configuration registers
  logic [1:0]               radius_r;
  logic [10:0]              fwidth_r, fheight_r;
  logic [COEF_REG_BITS-1:0] coef_r [COEF_ROWS];
  logic                     cfg_wr, geom_wr;
  reg_idx_t                 cfg_idx;

  logic [1:0]  r_eff;
  logic [CW:0] w_eff;
  logic [RB-1:0] h_eff;

  // stream counters
  logic [RB-1:0] in_row_r, out_row_r, in_row_nxt, out_row_nxt;
  logic [CW-1:0] in_col_r, out_col_r, in_col_nxt, out_col_nxt;
  logic [SW-1:0] in_slot_r, out_slot_r, in_slot_nxt, out_slot_nxt;

  logic accept, is_pix, restart_px, we, emit, win_ready;
  logic [RB-1:0] b_in_row, b_out_row;
  logic [CW-1:0] b_in_col, b_out_col;
  logic [SW-1:0] b_in_slot, b_out_slot;
  logic [RB:0]   lr_sum;
  logic [RB-1:0] lr;
  logic [CW:0]   lc_sum, lc;
  pixel_t        px;
  logic [XW-1:0] wcol_ext, base;
  logic [AW-1:0] waddr;
  logic [NBL-1:0] wbank;
  logic [AW-1:0] raddr [NB];
  logic [NB-1:0] fwd_hit;
  tok_t          tok;
  geom_t         geom;

  logic          pipe_en;
  logic          s1_valid_r;
  tok_t          s1_tok_r;
  logic [NB-1:0] fwd_hit_r;
  logic [SW-1:0] fwd_slot_r;
  pixel_t        fwd_data_r;
  pixel_t        ram_q [RING][NB];
  pixel_t        win   [RING][NB];

  logic          f_valid;
  res_t          f_res;
  logic          out_valid_r;
  res_t          out_res_r;
  logic          out_behind;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite;
  assign geom_wr = cfg_wr && (cfg_idx == REG_RADIUS || cfg_idx == REG_WIDTH ||
                              cfg_idx == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= 2'd1;
      fwidth_r  <= 11'd1024;
      fheight_r <= 11'd1024;
      for (int i = 0; i < COEF_ROWS; i++) begin
        coef_r[i] <= '0;
      end
      coef_r[2][COEF_BITS*2+8] <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_RADIUS: radius_r  <= pwdata[1:0];
        REG_WIDTH:  fwidth_r  <= pwdata[10:0];
        REG_HEIGHT: fheight_r <= pwdata[10:0];
        REG_COEF0:  coef_r[0] <= pwdata[COEF_REG_BITS-1:0];
        REG_COEF1:  coef_r[1] <= pwdata[COEF_REG_BITS-1:0];
        REG_COEF2:  coef_r[2] <= pwdata[COEF_REG_BITS-1:0];
        REG_COEF3:  coef_r[3] <= pwdata[COEF_REG_BITS-1:0];
        REG_COEF4:  coef_r[4] <= pwdata[COEF_REG_BITS-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_RADIUS: prdata = CFG_DATA_BITS'(radius_r);
      REG_WIDTH:  prdata = CFG_DATA_BITS'(fwidth_r);
      REG_HEIGHT: prdata = CFG_DATA_BITS'(fheight_r);
      REG_COEF0:  prdata = CFG_DATA_BITS'(coef_r[0]);
      REG_COEF1:  prdata = CFG_DATA_BITS'(coef_r[1]);
      REG_COEF2:  prdata = CFG_DATA_BITS'(coef_r[2]);
      REG_COEF3:  prdata = CFG_DATA_BITS'(coef_r[3]);
      REG_COEF4:  prdata = CFG_DATA_BITS'(coef_r[4]);
      default:    prdata = '0;
    endcase
  end

  // effective geometry
  always_comb begin
    r_eff = (radius_r > 2'(KR)) ? 2'(KR) : radius_r;
    if (fwidth_r == 11'd0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(fwidth_r) > 32'(MAX_WIDTH)) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(fwidth_r);
    end
    if (fheight_r == 11'd0) begin
      h_eff = RB'(1);
    end else if (32'(fheight_r) > 32'(HEIGHT_CAP)) begin
      h_eff = RB'(HEIGHT_CAP);
    end else begin
      h_eff = RB'(fheight_r);
    end
  end

  // issue: line store write and window read for the released position
  assign accept     = in_valid && in_ready;
  assign is_pix     = (op_t'(in_operation) == OP_PIXEL);
  assign restart_px = accept && is_pix && (in_row_r >= h_eff);
  assign we         = accept && is_pix;
  assign px         = {in_red, in_green, in_blue};

  always_comb begin
    b_in_row   = restart_px ? '0 : in_row_r;
    b_in_col   = restart_px ? '0 : in_col_r;
    b_in_slot  = restart_px ? '0 : in_slot_r;
    b_out_row  = restart_px ? '0 : out_row_r;
    b_out_col  = restart_px ? '0 : out_col_r;
    b_out_slot = restart_px ? '0 : out_slot_r;

    in_row_nxt  = b_in_row;
    in_col_nxt  = b_in_col;
    in_slot_nxt = b_in_slot;
    if (we) begin
      if (({1'b0, b_in_col} + (CW+1)'(1)) == w_eff) begin
        in_col_nxt  = '0;
        in_row_nxt  = b_in_row + RB'(1);
        in_slot_nxt = (b_in_slot == SW'(RING - 1)) ? '0 : b_in_slot + SW'(1);
      end else begin
        in_col_nxt = b_in_col + CW'(1);
      end
    end

    lr_sum    = {1'b0, b_out_row} + (RB+1)'(r_eff);
    lr        = (lr_sum > {1'b0, h_eff - RB'(1)}) ? h_eff - RB'(1) : lr_sum[RB-1:0];
    lc_sum    = {1'b0, b_out_col} + (CW+1)'(r_eff);
    lc        = (lc_sum > w_eff - (CW+1)'(1)) ? w_eff - (CW+1)'(1) : lc_sum;
    win_ready = (lr < in_row_nxt) || ((lr == in_row_nxt) && (lc < {1'b0, in_col_nxt}));
    emit      = accept && (b_out_row < h_eff) && win_ready;

    out_row_nxt  = b_out_row;
    out_col_nxt  = b_out_col;
    out_slot_nxt = b_out_slot;
    if (emit) begin
      if (({1'b0, b_out_col} + (CW+1)'(1)) == w_eff) begin
        out_col_nxt  = '0;
        out_row_nxt  = b_out_row + RB'(1);
        out_slot_nxt = (b_out_slot == SW'(RING - 1)) ? '0 : b_out_slot + SW'(1);
      end else begin
        out_col_nxt = b_out_col + CW'(1);
      end
    end

    if (geom_wr) begin
      in_row_nxt   = '0;
      in_col_nxt   = '0;
      in_slot_nxt  = '0;
      out_row_nxt  = '0;
      out_col_nxt  = '0;
      out_slot_nxt = '0;
    end
  end

  assign wcol_ext = XW'(b_in_col);
  assign waddr    = wcol_ext[NBL +: AW];
  assign wbank    = b_in_col[NBL-1:0];
  assign base     = XW'(b_out_col) - XW'(KR);

  always_comb begin
    for (int b = 0; b < NB; b++) begin
      logic [NBL-1:0] off;
      logic [XW-1:0]  xb;
      off      = NBL'(b) - base[NBL-1:0];
      xb       = base + XW'(off);
      raddr[b] = xb[NBL +: AW];
      fwd_hit[b] = we && (wbank == NBL'(b)) && (waddr == raddr[b]);
    end
  end

  assign tok.row       = b_out_row;
  assign tok.col       = COL_MAX_BITS'(b_out_col);
  assign tok.slot      = SLOT_MAX_BITS'(b_out_slot);
  assign tok.frame_end = (b_out_row == h_eff - RB'(1)) &&
                         ({1'b0, b_out_col} == w_eff - (CW+1)'(1));

  assign geom.radius = r_eff;
  assign geom.width  = WIDTH_BITS'(w_eff);
  assign geom.height = h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_slot_r  <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_slot_r <= '0;
    end else begin
      in_row_r   <= in_row_nxt;
      in_col_r   <= in_col_nxt;
      in_slot_r  <= in_slot_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
      out_slot_r <= out_slot_nxt;
    end
  end

  // line store banks
  for (genvar gs = 0; gs < RING; gs++) begin : g_slot
    for (genvar gb = 0; gb < NB; gb++) begin : g_bank
      ikc_ram #(
        .WIDTH (PIX_BITS),
        .DEPTH (RDEPTH)
      ) u_ram (
        .clk   (clk),
        .we    (we && (b_in_slot == SW'(gs)) && (wbank == NBL'(gb))),
        .waddr (waddr),
        .wdata (px),
        .re    (pipe_en),
        .raddr (raddr[gb]),
        .rdata (ram_q[gs][gb])
      );
      assign win[gs][gb] = (fwd_hit_r[gb] && (fwd_slot_r == SW'(gs))) ? fwd_data_r :
                           ram_q[gs][gb];
    end
  end

  // read stage with same-cycle write forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_tok_r   <= tok;
      fwd_hit_r  <= fwd_hit;
      fwd_slot_r <= b_in_slot;
      fwd_data_r <= px;
    end
  end

  ikc_filter #(
    .MAX_RADIUS (MAX_RADIUS),
    .COEF_BITS  (COEF_BITS)
  ) u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .tok_valid (s1_valid_r),
    .tok       (s1_tok_r),
    .geom      (geom),
    .coef      (coef_r),
    .win       (win),
    .res_valid (f_valid),
    .res       (f_res)
  );

  // output register
  assign pipe_en  = !(out_valid_r && !out_ready && f_valid);
  assign in_ready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_valid && (!out_valid_r || out_ready)) begin
      out_res_r <= f_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_res_r.red;
  assign out_green     = out_res_r.green;
  assign out_blue      = out_res_r.blue;
  assign out_frame_end = out_res_r.frame_end;

  assign out_behind = (out_row_r < in_row_r) ||
                      ((out_row_r == in_row_r) && (out_col_r <= in_col_r));

  `IKC_ASSERT(a_in_row_range, in_row_r <= h_eff)
  `IKC_ASSERT(a_in_col_range, {1'b0, in_col_r} < w_eff)
  `IKC_ASSERT(a_out_not_ahead, out_behind)
  `IKC_ASSERT(a_slot_range, ({1'b0, in_slot_r} < (SW+1)'(RING)) && ({1'b0, out_slot_r} < (SW+1)'(RING)))
  `IKC_ASSERT_NEXT(a_stall_hold, !pipe_en, $stable(s1_valid_r))

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// self-checking testbench for image_kernel_convolution: scoreboard class with a pixel-exact
// convolution predictor, plain tasks for the stream and apb ports; depends on ikc_pkg and the rtl
`timescale 1ns / 1ps
module tb_top;
  import ikc_pkg::*;

  localparam int LINE_W   = 1024;
  localparam int RING     = 6;
  localparam int IDLE_MAX = 3000;

  class raster_scoreboard;
    bit [63:0] regs [8];
    bit [23:0] line_mem [RING*LINE_W];
    int unsigned in_row, in_col, out_row, out_col;
    res_t expected_pixels [$];
    int errors, n_in, n_out, n_frame_ends;

    function new();
      regs = '{default: 0};
      regs[REG_RADIUS] = 1;
      regs[REG_WIDTH]  = 1024;
      regs[REG_HEIGHT] = 1024;
      regs[REG_COEF2]  = 64'h1 << 32;
      foreach (line_mem[i]) line_mem[i] = '0;
      restart();
    endfunction

    function void restart();
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    endfunction

    function int unsigned width();
      if (regs[REG_WIDTH] == 0) return 1;
      if (regs[REG_WIDTH] > LINE_W) return LINE_W;
      return regs[REG_WIDTH];
    endfunction

    function int unsigned height();
      if (regs[REG_HEIGHT] == 0) return 1;
      if (regs[REG_HEIGHT] > HEIGHT_CAP) return HEIGHT_CAP;
      return regs[REG_HEIGHT];
    endfunction

    function int radius();
      int r;
      r = regs[REG_RADIUS] & 3;
      return (r > 2) ? 2 : r;
    endfunction

    function bit pending();
      return out_row < height();
    endfunction

    function void write_reg(reg_idx_t idx, bit [63:0] val);
      if (idx == REG_RADIUS) val &= 64'h3;
      else if (idx <= REG_HEIGHT) val &= 64'h7ff;
      else val &= 64'h0fff_ffff_ffff_ffff;
      regs[idx] = val;
      if (idx <= REG_HEIGHT) restart();
    endfunction

    function bit [23:0] pix_at(int unsigned row, int unsigned col);
      return line_mem[(row % RING) * LINE_W + (col % LINE_W)];
    endfunction

    function bit [7:0] round_sat(longint s);
      longint t;
      t = s + 128;
      if (t < 0) return 0;
      t = t >>> 8;
      return (t > 255) ? 8'd255 : t[7:0];
    endfunction

    function void convolve_next();
      int unsigned w, h, lr, lc;
      int r, ty, tx;
      longint needed, received, k;
      longint acc [3];
      bit [23:0] centre, p;
      bit signed [11:0] tap;
      res_t e;
      w = width(); h = height(); r = radius();
      if (out_row >= h) return;
      lr = out_row + r; if (lr > h - 1) lr = h - 1;
      lc = out_col + r; if (lc > w - 1) lc = w - 1;
      needed = longint'(lr) * w + lc;
      received = longint'(in_row) * w + in_col;
      if (needed >= received) return;
      centre = pix_at(out_row, out_col);
      acc = '{0, 0, 0};
      for (int dy = -r; dy <= r; dy++) begin
        for (int dx = -r; dx <= r; dx++) begin
          ty = int'(out_row) + dy;
          tx = int'(out_col) + dx;
          tap = regs[3 + dy + 2][12*(dx+2) +: 12];
          k = tap;
          if (ty < 0 || ty >= int'(h) || tx < 0 || tx >= int'(w)) p = centre;
          else p = pix_at(ty, tx);
          acc[0] += longint'(p[23:16]) * k;
          acc[1] += longint'(p[15:8]) * k;
          acc[2] += longint'(p[7:0]) * k;
        end
      end
      e.red = round_sat(acc[0]);
      e.green = round_sat(acc[1]);
      e.blue = round_sat(acc[2]);
      e.frame_end = (out_row == h - 1 && out_col == w - 1);
      expected_pixels.push_back(e);
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    endfunction

    function void note_input(op_t op, bit [7:0] r, bit [7:0] g, bit [7:0] b);
      n_in++;
      if (op == OP_PIXEL) begin
        if (in_row >= height()) restart();
        line_mem[(in_row % RING) * LINE_W + (in_col % LINE_W)] = {r, g, b};
        in_col++;
        if (in_col >= width()) begin
          in_col = 0;
          in_row++;
        end
      end
      convolve_next();
    endfunction

    function void check_result(res_t got);
      res_t e;
      n_out++;
      if (got.frame_end) n_frame_ends++;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result transaction %p", got);
        errors++;
        return;
      end
      e = expected_pixels.pop_front();
      if (got.red !== e.red) begin
        $error("out_red: expected %0d actual %0d", e.red, got.red); errors++;
      end
      if (got.green !== e.green) begin
        $error("out_green: expected %0d actual %0d", e.green, got.green); errors++;
      end
      if (got.blue !== e.blue) begin
        $error("out_blue: expected %0d actual %0d", e.blue, got.blue); errors++;
      end
      if (got.frame_end !== e.frame_end) begin
        $error("out_frame_end: expected %0b actual %0b", e.frame_end, got.frame_end);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, in_operation;
  logic [7:0] in_red, in_green, in_blue;
  logic out_valid, out_ready, out_frame_end;
  logic [7:0] out_red, out_green, out_blue;
  logic psel, penable, pwrite, pready;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata, prdata;

  image_kernel_convolution dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_frame_end(out_frame_end),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  raster_scoreboard sb = new();
  int in_accepts, idle_cycles, burst_left, stall_mode, frames, geom_writes, coef_writes;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // monitors
  always @(posedge clk) begin : mon
    bit busy;
    busy = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_input(op_t'(in_operation), in_red, in_green, in_blue);
        in_accepts <= in_accepts + 1;
        busy = 1'b1;
      end
      if (out_valid && out_ready) begin
        sb.check_result('{out_red, out_green, out_blue, out_frame_end});
        busy = 1'b1;
      end
      if (psel && penable && pwrite && pready) begin
        sb.write_reg(reg_idx_t'(paddr >> 3), pwdata);
        busy = 1'b1;
      end
      idle_cycles <= busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_MAX);
        $display("status: fail");
        $finish;
      end
    end
  end

  // receiver stall pattern: always ready, random, or long stalls
  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 19) == 0) ? ~out_ready : out_ready;
    endcase
  end

  task automatic send_item(op_t op, bit [7:0] r, bit [7:0] g, bit [7:0] b);
    int n;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid = 1'b1;
    in_operation = op;
    in_red = r; in_green = g; in_blue = b;
    n = in_accepts;
    do @(negedge clk); while (in_accepts == n);
    in_valid = 1'b0;
  endtask

  task automatic send_pixel();
    send_item(OP_PIXEL, $urandom, $urandom, $urandom);
  endtask

  task automatic send_flush();
    send_item(OP_FLUSH, $urandom, $urandom, $urandom);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    burst_left = 0;
    while (sb.expected_pixels.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, bit [63:0] val);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = idx << 3; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  function automatic bit [63:0] rand_coefs();
    bit [63:0] v;
    v = {$urandom, $urandom};
    for (int k = 0; k < 5; k++) begin
      case ($urandom_range(0, 5))
        0: v[12*k +: 12] = 0;
        1: v[12*k +: 12] = $urandom_range(0, 1) ? 12'h7ff : 12'h800;
        2, 3: v[12*k +: 12] = $urandom_range(0, 160) - 80;
        default: v[12*k +: 12] = $urandom;
      endcase
    end
    return v;
  endfunction

  task automatic set_geometry(int unsigned rad, int unsigned w, int unsigned h);
    apb_write(REG_RADIUS, rad);
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
    geom_writes++;
  endtask

  task automatic set_coefs();
    apb_write(REG_COEF0, rand_coefs());
    apb_write(REG_COEF1, rand_coefs());
    apb_write(REG_COEF2, rand_coefs());
    apb_write(REG_COEF3, rand_coefs());
    apb_write(REG_COEF4, rand_coefs());
    coef_writes++;
  endtask

  // whole frame with scattered flushes, then flush out the tail unless the frame is cut short
  task automatic run_frame(bit full_tail);
    int unsigned total;
    total = sb.width() * sb.height();
    for (int unsigned i = 0; i < total; i++) begin
      if ($urandom_range(0, 9) == 0) send_flush();
      send_pixel();
    end
    if (full_tail) begin
      while (sb.pending()) send_flush();
      if ($urandom_range(0, 3) == 0) send_flush();
    end else begin
      repeat ($urandom_range(0, 3)) send_flush();
    end
    frames++;
  endtask

  initial begin
    int unsigned w, h;
    rst_n = 1'b0;
    in_valid = 1'b0; in_operation = OP_PIXEL;
    in_red = 0; in_green = 0; in_blue = 0;
    out_ready = 1'b1; stall_mode = 0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_accepts = 0; idle_cycles = 0; burst_left = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed: flush with nothing ready, extreme pixels and taps, clamped geometry
    send_flush();
    set_geometry(3, 3, 2);
    apb_write(REG_COEF0, 64'hfff0_0000_0000_07ff);
    apb_write(REG_COEF1, {4'hf, 12'h800, 12'h7ff, 12'h800, 12'h7ff, 12'h800});
    apb_write(REG_COEF2, {4'h0, 12'h001, 12'hfff, 12'h100, 12'hfff, 12'h001});
    apb_write(REG_COEF3, {4'h0, 12'h7ff, 12'h7ff, 12'h7ff, 12'h7ff, 12'h7ff});
    apb_write(REG_COEF4, '0);
    coef_writes++;
    send_item(OP_PIXEL, 8'hff, 8'h00, 8'hff);
    send_item(OP_PIXEL, 8'h00, 8'hff, 8'h00);
    send_item(OP_PIXEL, 8'hff, 8'hff, 8'hff);
    send_item(OP_PIXEL, 8'h00, 8'h00, 8'h00);
    send_flush();
    send_item(OP_PIXEL, 8'h80, 8'h7f, 8'h01);
    send_item(OP_PIXEL, 8'hfe, 8'h01, 8'h80);
    while (sb.pending()) send_flush();
    send_flush();
    // pixel after complete frame, then restart with tail left unflushed
    run_frame(1'b0);
    run_frame(1'b1);
    drain();
    set_geometry(0, 0, 0);
    run_frame(1'b1);
    drain();
    set_geometry(2, 2047, 1);
    run_frame(1'b1);
    drain();
    // clamped height: a partial frame, cut off by the next geometry write
    set_geometry(1, 1, 2047);
    repeat (60) send_pixel();
    drain();
    set_geometry(1, 8, 6);

    while (sb.n_in < 1400) begin
      if ($urandom_range(0, 2) == 0) set_coefs();
      if ($urandom_range(0, 1) == 0) begin
        w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
        h = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 8);
        if ($urandom_range(0, 30) == 0) begin
          w = 1024; h = 1;
        end
        set_geometry($urandom_range(0, 3), w, h);
      end
      run_frame($urandom_range(0, 7) != 0);
      if ($urandom_range(0, 1) == 0) run_frame(1'b1);
      drain();
    end
    drain();

    $display("covered %0d frames, %0d geometry and %0d coefficient settings",
             frames, geom_writes, coef_writes);
    $display("%0d input and %0d result transactions, %0d frame ends",
             sb.n_in, sb.n_out, sb.n_frame_ends);
    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+src
src/ikc_pkg.sv
src/ikc_ram.sv
src/ikc_filter.sv
src/image_kernel_convolution.sv
verif/tb_top.sv
